@@ src/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the segment intersection block
// Widths of every pipeline quantity follow from the coordinate and fraction
// widths, together with the register codes and the payload structures.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 4;

	localparam int TOL_BITS   = 5;
	localparam int SIZE_BITS  = 11;
	localparam int OUT_BITS   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SIZE_BITS;

	localparam logic [TOL_BITS-1:0]  TOL_RESET    = TOL_BITS'(5);
	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * COORD_BITS;
	localparam int CROSS_W = PROD_W + 1;
	localparam int DPROD_W = 2 * DIFF_W;
	localparam int DET_W   = DPROD_W + 1;
	localparam int NPROD_W = CROSS_W + DIFF_W;
	localparam int NUM_W   = NPROD_W + 1;
	localparam int NABS_W  = NUM_W + FRAC_BITS;
	localparam int Q_BITS  = COORD_BITS + FRAC_BITS + 1;
	localparam int NDIV    = Q_BITS + 1;
	localparam int REM_W   = (NABS_W > DET_W + Q_BITS) ? NABS_W : DET_W + Q_BITS;
	localparam int CMP_W   = (COORD_BITS + FRAC_BITS + 2 > SIZE_BITS + FRAC_BITS + 1) ?
		COORD_BITS + FRAC_BITS + 2 : SIZE_BITS + FRAC_BITS + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOL    = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} sit_cfg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] a_start_x;
		logic [COORD_BITS-1:0] a_start_y;
		logic [COORD_BITS-1:0] a_end_x;
		logic [COORD_BITS-1:0] a_end_y;
		logic [COORD_BITS-1:0] b_start_x;
		logic [COORD_BITS-1:0] b_start_y;
		logic [COORD_BITS-1:0] b_end_x;
		logic [COORD_BITS-1:0] b_end_y;
	} sit_seg_t;

	typedef struct packed {
		logic                       hit;
		logic signed [OUT_BITS-1:0] cross_x;
		logic signed [OUT_BITS-1:0] cross_y;
	} sit_res_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] ax_lo;
		logic [COORD_BITS-1:0] ax_hi;
		logic [COORD_BITS-1:0] ay_lo;
		logic [COORD_BITS-1:0] ay_hi;
		logic [COORD_BITS-1:0] bx_lo;
		logic [COORD_BITS-1:0] bx_hi;
		logic [COORD_BITS-1:0] by_lo;
		logic [COORD_BITS-1:0] by_hi;
	} sit_box_t;

	typedef struct packed {
		logic [REM_W-1:0] rem_x;
		logic [REM_W-1:0] rem_y;
		logic [REM_W-1:0] dsh;
		logic [Q_BITS:0]  q_x;
		logic [Q_BITS:0]  q_y;
		logic             sx;
		logic             sy;
		logic             dz;
		sit_box_t         box;
	} sit_div_t;

endpackage

@@ src/sit_if.sv @@
// ----------------------------------------------------------------------------
// sit_if: handshake channels of the segment intersection block
// Segment pair input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface sit_seg_if;
	import sit_pkg::*;

	logic     valid;
	logic     ready;
	sit_seg_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sit_res_if;
	import sit_pkg::*;

	logic     valid;
	logic     ready;
	sit_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sit_cfg_if;
	import sit_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/segment_intersection_tolerant_top.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_tolerant_top: crossing point of two line segments
// One segment pair enters every cycle while the result buffer has room.
// The rate is set by the fully pipelined multipliers and by the divider,
// which resolves one quotient bit per stage for x and y in parallel.
// Reset clears all valid bits and the result buffer and loads the registers
// with a tolerance of 5 and an image size of 640 by 480.
// ----------------------------------------------------------------------------
module segment_intersection_tolerant_top (
	input  logic      clk,
	input  logic      arst_n,
	sit_seg_if.sink   segs,
	sit_res_if.source result,
	sit_cfg_if.sink   cfg
);
	import sit_pkg::*;

	function automatic logic signed [CMP_W-1:0] fix_lo(
		input logic [COORD_BITS-1:0] v,
		input logic [TOL_BITS-1:0]   t
	);
		logic [CMP_W-1:0] r;
		r      = (CMP_W'(v) - CMP_W'(t)) << FRAC_BITS;
		fix_lo = $signed(r);
	endfunction

	function automatic logic signed [CMP_W-1:0] fix_hi(
		input logic [COORD_BITS-1:0] v,
		input logic [TOL_BITS-1:0]   t
	);
		logic [CMP_W-1:0] r;
		r      = (CMP_W'(v) + CMP_W'(t)) << FRAC_BITS;
		fix_hi = $signed(r);
	endfunction

	logic [TOL_BITS-1:0]  tol_q;
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	logic                 en;
	logic                 full;

	logic [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_f1, v_f2;
	logic signed [DIFF_W-1:0]  da_x_s1, da_y_s1, db_x_s1, db_y_s1;
	logic [PROD_W-1:0]         pa1_s1, pa2_s1, pb1_s1, pb2_s1;
	sit_box_t                  box_s1, box_s2, box_s3, box_s4;

	logic signed [DIFF_W-1:0]  da_x_s2, da_y_s2, db_x_s2, db_y_s2;
	logic signed [CROSS_W-1:0] ca_s2, cb_s2;
	logic signed [DPROD_W-1:0] dp1_s2, dp2_s2;

	logic signed [DET_W-1:0]   det_s3, det_s4;
	logic signed [NPROD_W-1:0] m1_s3, m2_s3, m3_s3, m4_s3;

	logic signed [NUM_W-1:0]   nx_s4, ny_s4;

	sit_div_t                  div_s5;
	logic [NUM_W-1:0]          nx_mag, ny_mag;
	logic [DET_W-1:0]          det_mag;

	sit_div_t                  div_d [NDIV+1];
	logic                      div_v [NDIV+1];

	sit_div_t                  div_last;
	logic signed [CMP_W-1:0]   px_abs, py_abs;
	logic signed [CMP_W-1:0]   px_f1, py_f1;
	logic                      ok_f1;
	logic signed [CMP_W-1:0]   axl_f1, axh_f1, ayl_f1, ayh_f1;
	logic signed [CMP_W-1:0]   bxl_f1, bxh_f1, byl_f1, byh_f1;

	logic signed [CMP_W-1:0]   w_fix, h_fix;
	logic                      hit;
	sit_res_t                  res_f2;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_TOL:    tol_q    <= cfg.data[TOL_BITS-1:0];
				CFG_WIDTH:  width_q  <= cfg.data[SIZE_BITS-1:0];
				CFG_HEIGHT: height_q <= cfg.data[SIZE_BITS-1:0];
				default:    ;
			endcase
		end
	end

	// The whole pipeline moves together while the result buffer has room.
	assign en         = !full;
	assign segs.ready = en;

	assign x1 = segs.data.a_start_x;
	assign y1 = segs.data.a_start_y;
	assign x2 = segs.data.a_end_x;
	assign y2 = segs.data.a_end_y;
	assign x3 = segs.data.b_start_x;
	assign y3 = segs.data.b_start_y;
	assign x4 = segs.data.b_end_x;
	assign y4 = segs.data.b_end_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (en) begin
			v_s1 <= segs.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_f1 <= div_v[NDIV];
			v_f2 <= v_f1;
		end
	end

	// Stage 1: coordinate differences, cross products and bounding boxes.
	always_ff @(posedge clk) begin
		if (en) begin
			da_x_s1      <= $signed({1'b0, x1}) - $signed({1'b0, x2});
			da_y_s1      <= $signed({1'b0, y1}) - $signed({1'b0, y2});
			db_x_s1      <= $signed({1'b0, x3}) - $signed({1'b0, x4});
			db_y_s1      <= $signed({1'b0, y3}) - $signed({1'b0, y4});
			pa1_s1       <= x1 * y2;
			pa2_s1       <= y1 * x2;
			pb1_s1       <= x3 * y4;
			pb2_s1       <= y3 * x4;
			box_s1.ax_lo <= (x1 < x2) ? x1 : x2;
			box_s1.ax_hi <= (x1 < x2) ? x2 : x1;
			box_s1.ay_lo <= (y1 < y2) ? y1 : y2;
			box_s1.ay_hi <= (y1 < y2) ? y2 : y1;
			box_s1.bx_lo <= (x3 < x4) ? x3 : x4;
			box_s1.bx_hi <= (x3 < x4) ? x4 : x3;
			box_s1.by_lo <= (y3 < y4) ? y3 : y4;
			box_s1.by_hi <= (y3 < y4) ? y4 : y3;
		end
	end

	// Stage 2: line constants and determinant products.
	always_ff @(posedge clk) begin
		if (en) begin
			ca_s2   <= $signed({1'b0, pa1_s1}) - $signed({1'b0, pa2_s1});
			cb_s2   <= $signed({1'b0, pb1_s1}) - $signed({1'b0, pb2_s1});
			dp1_s2  <= DPROD_W'(da_x_s1) * DPROD_W'(db_y_s1);
			dp2_s2  <= DPROD_W'(da_y_s1) * DPROD_W'(db_x_s1);
			da_x_s2 <= da_x_s1;
			da_y_s2 <= da_y_s1;
			db_x_s2 <= db_x_s1;
			db_y_s2 <= db_y_s1;
			box_s2  <= box_s1;
		end
	end

	// Stage 3: determinant and numerator products.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= DET_W'(dp1_s2) - DET_W'(dp2_s2);
			m1_s3  <= NPROD_W'(ca_s2) * NPROD_W'(db_x_s2);
			m2_s3  <= NPROD_W'(da_x_s2) * NPROD_W'(cb_s2);
			m3_s3  <= NPROD_W'(ca_s2) * NPROD_W'(db_y_s2);
			m4_s3  <= NPROD_W'(da_y_s2) * NPROD_W'(cb_s2);
			box_s3 <= box_s2;
		end
	end

	// Stage 4: numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4  <= NUM_W'(m1_s3) - NUM_W'(m2_s3);
			ny_s4  <= NUM_W'(m3_s3) - NUM_W'(m4_s3);
			det_s4 <= det_s3;
			box_s4 <= box_s3;
		end
	end

	// Stage 5: magnitudes and signs, divisor aligned to the top quotient bit.
	assign nx_mag  = nx_s4[NUM_W-1] ? NUM_W'(-nx_s4) : NUM_W'(nx_s4);
	assign ny_mag  = ny_s4[NUM_W-1] ? NUM_W'(-ny_s4) : NUM_W'(ny_s4);
	assign det_mag = det_s4[DET_W-1] ? DET_W'(-det_s4) : DET_W'(det_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			div_s5.rem_x <= REM_W'(nx_mag) << FRAC_BITS;
			div_s5.rem_y <= REM_W'(ny_mag) << FRAC_BITS;
			div_s5.dsh   <= REM_W'(det_mag) << Q_BITS;
			div_s5.q_x   <= '0;
			div_s5.q_y   <= '0;
			div_s5.sx    <= nx_s4[NUM_W-1] ^ det_s4[DET_W-1];
			div_s5.sy    <= ny_s4[NUM_W-1] ^ det_s4[DET_W-1];
			div_s5.dz    <= det_s4 == '0;
			div_s5.box   <= box_s4;
		end
	end

	// Divider: the first stage flags a quotient too large for any hit.
	assign div_d[0] = div_s5;
	assign div_v[0] = v_s5;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		sit_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (div_v[i]),
			.d_in   (div_d[i]),
			.vout   (div_v[i+1]),
			.d_out  (div_d[i+1])
		);
	end

	// Final stage 1: signed quotients and widened box bounds.
	assign div_last = div_d[NDIV];
	assign px_abs   = $signed(CMP_W'(div_last.q_x[Q_BITS-1:0]));
	assign py_abs   = $signed(CMP_W'(div_last.q_y[Q_BITS-1:0]));

	always_ff @(posedge clk) begin
		if (en) begin
			px_f1  <= div_last.sx ? -px_abs : px_abs;
			py_f1  <= div_last.sy ? -py_abs : py_abs;
			ok_f1  <= !div_last.dz && !div_last.q_x[Q_BITS] && !div_last.q_y[Q_BITS];
			axl_f1 <= fix_lo(div_last.box.ax_lo, tol_q);
			axh_f1 <= fix_hi(div_last.box.ax_hi, tol_q);
			ayl_f1 <= fix_lo(div_last.box.ay_lo, tol_q);
			ayh_f1 <= fix_hi(div_last.box.ay_hi, tol_q);
			bxl_f1 <= fix_lo(div_last.box.bx_lo, tol_q);
			bxh_f1 <= fix_hi(div_last.box.bx_hi, tol_q);
			byl_f1 <= fix_lo(div_last.box.by_lo, tol_q);
			byh_f1 <= fix_hi(div_last.box.by_hi, tol_q);
		end
	end

	// Final stage 2: box and image tests.
	assign w_fix = $signed(CMP_W'(width_q) << FRAC_BITS);
	assign h_fix = $signed(CMP_W'(height_q) << FRAC_BITS);

	assign hit = ok_f1
		&& px_f1 >= axl_f1 && px_f1 <= axh_f1
		&& py_f1 >= ayl_f1 && py_f1 <= ayh_f1
		&& px_f1 >= bxl_f1 && px_f1 <= bxh_f1
		&& py_f1 >= byl_f1 && py_f1 <= byh_f1
		&& px_f1 >= $signed(CMP_W'(0)) && py_f1 >= $signed(CMP_W'(0))
		&& px_f1 < w_fix && py_f1 < h_fix;

	always_ff @(posedge clk) begin
		if (en) begin
			res_f2.hit     <= hit;
			res_f2.cross_x <= hit ? OUT_BITS'(px_f1) : '0;
			res_f2.cross_y <= hit ? OUT_BITS'(py_f1) : '0;
		end
	end

	sit_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && v_f2),
		.push_data (res_f2),
		.full      (full),
		.result    (result)
	);

endmodule

@@ src/sit_div_stage.sv @@
// ----------------------------------------------------------------------------
// sit_div_stage: one restoring division step for both coordinates
// Resolves one quotient bit of x and of y against a shared aligned divisor
// and registers the partial remainders with the item's sideband.
// ----------------------------------------------------------------------------
module sit_div_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  sit_pkg::sit_div_t d_in,
	output logic              vout,
	output sit_pkg::sit_div_t d_out
);
	import sit_pkg::*;

	sit_div_t nxt;
	logic     ge_x;
	logic     ge_y;

	always_comb begin
		ge_x      = d_in.rem_x >= d_in.dsh;
		ge_y      = d_in.rem_y >= d_in.dsh;
		nxt       = d_in;
		nxt.rem_x = ge_x ? d_in.rem_x - d_in.dsh : d_in.rem_x;
		nxt.rem_y = ge_y ? d_in.rem_y - d_in.dsh : d_in.rem_y;
		nxt.q_x   = {d_in.q_x[Q_BITS-1:0], ge_x};
		nxt.q_y   = {d_in.q_y[Q_BITS-1:0], ge_y};
		nxt.dsh   = d_in.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ src/sit_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sit_out_fifo: two-entry result buffer
// Decouples the pipeline from the result channel so that one waiting result
// does not stop new items from entering.
// ----------------------------------------------------------------------------
module sit_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sit_pkg::sit_res_t push_data,
	output logic              full,
	sit_res_if.source         result
);
	import sit_pkg::*;

	localparam logic [1:0] FULL_CNT = 2'd2;

	sit_res_t   mem_q [2];
	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	logic       pop;

	assign full         = count_q == FULL_CNT;
	assign result.valid = count_q != 2'd0;
	assign result.data  = mem_q[rd_q];
	assign pop          = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ src/sit_checker.sv @@
// ----------------------------------------------------------------------------
// sit_checker: port-level checks of the segment intersection block
// Watches the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module sit_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              res_valid,
	input logic              res_ready,
	input sit_pkg::sit_res_t res_data
);
	import sit_pkg::*;

	// A stalled result transaction keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// A miss carries a zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.hit |-> res_data.cross_x == '0 && res_data.cross_y == '0)
		else $error("miss with nonzero point");

	// A hit lies inside the image, so both coordinates are non-negative.
	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.hit |-> !res_data.cross_x[OUT_BITS-1] &&
			!res_data.cross_y[OUT_BITS-1])
		else $error("hit with negative point");

	// Input is held off only while results wait in the output buffer.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid)
		else $error("input stalled with no pending result");

endmodule

bind segment_intersection_tolerant_top sit_checker u_sit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (segs.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the segment intersection block
// Drives segment pairs and result back-pressure with random gaps and register
// writes between runs, predicts every result from its own copy of the registers,
// and checks each result against the oldest pending prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import sit_pkg::*;

	localparam int PIPE_LATENCY = COORD_BITS + FRAC_BITS + 10;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_FIRST = 250;
	localparam int RANDOM_EACH  = 215;
	localparam int TOLS[4]      = '{0, 31, 17, 3};
	localparam int WIDTHS[4]    = '{1024, 2047, 1, 0};
	localparam int HEIGHTS[4]   = '{1024, 2047, 1, 0};

	class crossing_scoreboard;
		logic [TOL_BITS-1:0]  tol;
		logic [SIZE_BITS-1:0] img_w;
		logic [SIZE_BITS-1:0] img_h;
		sit_res_t             crossings_due[$];
		int                   errors;
		int                   pairs;
		int                   hits;
		int                   flat;

		function new();
			tol    = TOL_RESET;
			img_w  = WIDTH_RESET;
			img_h  = HEIGHT_RESET;
			errors = 0;
			pairs  = 0;
			hits   = 0;
			flat   = 0;
		endfunction

		function void load_reg(sit_cfg_idx_t idx, int value);
			case (idx)
			CFG_TOL: tol = TOL_BITS'(value);
			CFG_WIDTH: img_w = SIZE_BITS'(value);
			CFG_HEIGHT: img_h = SIZE_BITS'(value);
			default: ;
			endcase
		endfunction

		function bit in_span(longint v, longint p, longint q, longint t);
			longint one;
			longint lo;
			longint hi;
			one = longint'(1) << FRAC_BITS;
			lo  = (p < q) ? p : q;
			hi  = (p > q) ? p : q;
			return v >= (lo - t) * one && v <= (hi + t) * one;
		endfunction

		function sit_res_t crossing_of(sit_seg_t s);
			longint   one, t, w, h, d, ca, cb, nx, ny, px, py;
			longint   x1, y1, x2, y2, x3, y3, x4, y4;
			bit       hit;
			sit_res_t r;
			one = longint'(1) << FRAC_BITS;
			t   = tol;
			w   = img_w;
			h   = img_h;
			x1  = s.a_start_x;
			y1  = s.a_start_y;
			x2  = s.a_end_x;
			y2  = s.a_end_y;
			x3  = s.b_start_x;
			y3  = s.b_start_y;
			x4  = s.b_end_x;
			y4  = s.b_end_y;
			hit = 1'b0;
			px  = 0;
			py  = 0;
			d   = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
			if (d != 0) begin
				ca  = x1 * y2 - y1 * x2;
				cb  = x3 * y4 - y3 * x4;
				nx  = ca * (x3 - x4) - (x1 - x2) * cb;
				ny  = ca * (y3 - y4) - (y1 - y2) * cb;
				px  = (nx * one) / d;
				py  = (ny * one) / d;
				hit = in_span(px, x1, x2, t) && in_span(py, y1, y2, t)
					&& in_span(px, x3, x4, t) && in_span(py, y3, y4, t)
					&& px >= 0 && py >= 0 && px < w * one && py < h * one;
			end else begin
				flat++;
			end
			r.hit     = hit;
			r.cross_x = hit ? OUT_BITS'(px) : '0;
			r.cross_y = hit ? OUT_BITS'(py) : '0;
			return r;
		endfunction

		function void note_pair(sit_seg_t s);
			sit_res_t r;
			r = crossing_of(s);
			pairs++;
			if (r.hit)
				hits++;
			crossings_due.insert(crossings_due.size(), r);
		endfunction

		function void check_result(sit_res_t got);
			sit_res_t want;
			if (crossings_due.size() == 0) begin
				$error("result with no segment pair pending: hit %0d, cross_x %0d, cross_y %0d",
					got.hit, got.cross_x, got.cross_y);
				errors++;
				return;
			end
			want = crossings_due.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, actual %0d", want.hit, got.hit);
				errors++;
			end
			if (got.cross_x !== want.cross_x) begin
				$error("cross_x: expected %0d, actual %0d", want.cross_x, got.cross_x);
				errors++;
			end
			if (got.cross_y !== want.cross_y) begin
				$error("cross_y: expected %0d, actual %0d", want.cross_y, got.cross_y);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sit_seg_if segs_if ();
	sit_res_if res_if ();
	sit_cfg_if cfg_if ();

	segment_intersection_tolerant_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.segs   (segs_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	crossing_scoreboard board = new();

	int unsigned cycles = 0;
	int          stall_cycles = 0;
	int          send_gap_max = 15;
	int          recv_gap_max = 15;
	bit          long_hold = 1'b0;
	int          settings = 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (segs_if.valid && segs_if.ready)
				board.note_pair(segs_if.data);
			if (segs_if.valid && !segs_if.ready)
				stall_cycles++;
			if (res_if.valid && res_if.ready)
				board.check_result(res_if.data);
		end
	end

	initial begin
		int gap;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			gap = $urandom_range(0, recv_gap_max);
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	function automatic int clip(int v);
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	function automatic int reach(int c, int d, int s);
		return c + d * s / 8;
	endfunction

	function automatic sit_seg_t make_pair(int ax1, int ay1, int ax2, int ay2,
		int bx1, int by1, int bx2, int by2);
		sit_seg_t s;
		s.a_start_x = COORD_BITS'(clip(ax1));
		s.a_start_y = COORD_BITS'(clip(ay1));
		s.a_end_x   = COORD_BITS'(clip(ax2));
		s.a_end_y   = COORD_BITS'(clip(ay2));
		s.b_start_x = COORD_BITS'(clip(bx1));
		s.b_start_y = COORD_BITS'(clip(by1));
		s.b_end_x   = COORD_BITS'(clip(bx2));
		s.b_end_y   = COORD_BITS'(clip(by2));
		return s;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 5))
		0, 1: return 0;
		2, 3: return 1023;
		4: return 1;
		default: return 1022;
		endcase
	endfunction

	function automatic sit_seg_t random_pair();
		int kind, cx, cy, r, ox, oy, sa, sb;
		int adx, ady, bdx, bdy, x1, y1, x3, y3;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			return make_pair($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
		end else if (kind < 22) begin
			adx = int'($urandom_range(0, 120)) - 60;
			ady = int'($urandom_range(0, 120)) - 60;
			x1  = $urandom_range(60, 963);
			y1  = $urandom_range(60, 963);
			x3  = $urandom_range(60, 963);
			y3  = $urandom_range(60, 963);
			case ($urandom_range(0, 4))
			0: return make_pair(x1, y1, x1 + adx, y1 + ady, x1, y1, x1 + adx, y1 + ady);
			1, 2: return make_pair(x1, y1, x1 + adx, y1 + ady, x3, y3, x3 + adx, y3 + ady);
			default: return make_pair(x1, y1, x1 + adx, y1 + ady, x3 + adx, y3 + ady, x3, y3);
			endcase
		end else if (kind < 30) begin
			return make_pair(extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord());
		end
		cx = ($urandom_range(0, 3) == 0) ? clip(int'(board.img_w) - 8 + int'($urandom_range(0, 16)))
			: int'($urandom_range(0, 1023));
		cy = ($urandom_range(0, 3) == 0) ? clip(int'(board.img_h) - 8 + int'($urandom_range(0, 16)))
			: int'($urandom_range(0, 1023));
		case ($urandom_range(0, 3))
		0: r = 3;
		1: r = 24;
		2: r = 160;
		default: r = 700;
		endcase
		adx = int'($urandom_range(0, 2 * r)) - r;
		ady = int'($urandom_range(0, 2 * r)) - r;
		bdx = int'($urandom_range(0, 2 * r)) - r;
		bdy = int'($urandom_range(0, 2 * r)) - r;
		ox  = 0;
		oy  = 0;
		if ($urandom_range(0, 2) == 0) begin
			ox = int'($urandom_range(0, 80)) - 40;
			oy = int'($urandom_range(0, 80)) - 40;
		end
		sa = $urandom_range(0, 8);
		sb = $urandom_range(0, 8);
		return make_pair(cx - adx, cy - ady, reach(cx, adx, sa), reach(cy, ady, sa),
			cx + ox - bdx, cy + oy - bdy, reach(cx + ox, bdx, sb), reach(cy + oy, bdy, sb));
	endfunction

	task automatic send_pair(sit_seg_t s);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			segs_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		segs_if.valid <= 1'b1;
		segs_if.data  <= s;
		do @(posedge clk); while (!segs_if.ready);
	endtask

	task automatic settle();
		segs_if.valid <= 1'b0;
		do @(posedge clk); while (board.crossings_due.size() != 0);
	endtask

	task automatic apply_setting(int tol, int width, int height);
		sit_cfg_idx_t idx;
		int           value;
		for (int i = 0; i < 3; i++) begin
			idx   = sit_cfg_idx_t'(i);
			value = (idx == CFG_TOL) ? tol : (idx == CFG_WIDTH) ? width : height;
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx;
			cfg_if.data  <= CFG_DATA_W'(value);
			do @(posedge clk); while (!cfg_if.ready);
			board.load_reg(idx, value);
		end
		cfg_if.valid <= 1'b0;
		settings++;
	endtask

	task automatic run_random(int count, bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				send_gap_max = ($urandom_range(0, 1) == 0) ? 0 : 15;
				recv_gap_max = ($urandom_range(0, 1) == 0) ? 0 : 15;
				if (with_hold && i == 100) begin
					send_gap_max = 0;
					long_hold    = 1'b1;
				end
			end
			send_pair(random_pair());
		end
	endtask

	initial begin
		segs_if.valid <= 1'b0;
		segs_if.data  <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.index  <= CFG_TOL;
		cfg_if.data   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
		send_pair(make_pair(0, 0, 100, 100, 0, 100, 100, 0));
		send_pair(make_pair(100, 100, 0, 0, 100, 0, 0, 100));
		send_pair(make_pair(0, 0, 1023, 1023, 0, 1023, 1023, 0));
		send_pair(make_pair(1023, 0, 0, 1023, 0, 0, 1023, 1023));
		send_pair(make_pair(10, 0, 10, 200, 0, 100, 300, 100));
		send_pair(make_pair(0, 0, 10, 10, 0, 5, 10, 15));
		send_pair(make_pair(0, 0, 10, 10, 20, 20, 30, 30));
		send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
		send_pair(make_pair(0, 10, 10, 10, 13, 0, 13, 20));
		send_pair(make_pair(0, 10, 10, 10, 15, 0, 15, 20));
		send_pair(make_pair(0, 10, 10, 10, 16, 0, 16, 20));
		send_pair(make_pair(0, 2, 1, 3, 0, 0, 1, 0));
		send_pair(make_pair(0, 48, 10, 48, 1, 0, 0, 47));
		send_pair(make_pair(639, 0, 639, 400, 600, 100, 700, 100));
		send_pair(make_pair(640, 0, 640, 400, 600, 100, 700, 100));
		send_pair(make_pair(0, 479, 600, 479, 300, 0, 300, 600));
		send_pair(make_pair(0, 480, 600, 480, 300, 0, 300, 600));
		send_pair(make_pair(1023, 0, 1023, 1023, 0, 1023, 1023, 1023));
		send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
		send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 10));
		run_random(RANDOM_FIRST, 1'b0);

		for (int p = 0; p < 6; p++) begin
			settle();
			if (p < 4)
				apply_setting(TOLS[p], WIDTHS[p], HEIGHTS[p]);
			else
				apply_setting($urandom_range(0, 31), $urandom_range(1, 1024),
					$urandom_range(1, 1024));
			run_random(RANDOM_EACH, p == 0);
		end

		settle();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (board.crossings_due.size() != 0) begin
			$error("%0d predicted results never arrived", board.crossings_due.size());
			board.errors++;
		end
		$display("Covered %0d segment pairs under %0d register settings: %0d hits, %0d on parallel or degenerate lines.",
			board.pairs, settings, board.hits, board.flat);
		$display("The block held off its input for %0d cycles while results were backed up.",
			stall_cycles);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ segment_intersection_tolerant_top.f @@
src/sit_pkg.sv
src/sit_if.sv
src/sit_div_stage.sv
src/sit_out_fifo.sv
src/segment_intersection_tolerant_top.sv
src/sit_checker.sv
test/tb_top.sv
